// File: src/rsvt_pkg.sv
// shared types, codes and defaults for the cpu and memory reservation table
package rsvt_pkg;

	localparam int CPU_SLOTS_DEF   = 32;
	localparam int MAX_ENTRIES_DEF = 16;

	typedef enum logic [1:0] {
		CMD_RESERVE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_FITS    = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] REG_CPU_PRESENT = 2'd0;
	localparam logic [1:0] REG_NODE_MEMORY = 2'd1;

	// one table entry; cnt is the popcount of mask, kept so release needs no recount
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] mask;
		logic [31:0] mem;
		logic [5:0]  cnt;
	} entry_t;

endpackage

// File: src/rsvt_cell.sv
// one table cell: holds an entry, takes its neighbor's entry on shift, or loads a new one
module rsvt_cell (
	input  logic            clk,
	input  logic            shift_en,
	input  logic            load_en,
	input  rsvt_pkg::entry_t load_data,
	input  rsvt_pkg::entry_t nbr_data,
	output rsvt_pkg::entry_t data
);

	rsvt_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			entry_q <= load_data;
		end else if (shift_en) begin
			entry_q <= nbr_data;
		end
	end

	assign data = entry_q;

endmodule

// File: src/cpu_memory_reservation_table_unit.sv
// top level of the cpu and memory reservation table
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------------------
// in      | input     | in_valid/in_stall  | cmd, job_tag, cpu_request, memory_request
// out     | output    | out_valid/out_stall| status, granted_mask, granted_memory, fits,
//         |           |                    | job_cpu_mask, free_cpus, free_memory
// cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// one transaction at a time; fits check goes from the idle state through the done state to the output register
// reserve walks the free mask one cpu a cycle, over up to min(CPU_SLOTS,32) cpus,
// stopping early when the requested count is met
// release and query rotate the cell chain once, through every live entry
// after reset the free cpu count is already valid; a register write empties the
// table and recounts the present mask one bit a cycle over min(CPU_SLOTS,32) bits,
// with in_stall high meanwhile
// a finished result waits in the done state while out_stall holds the output register
module cpu_memory_reservation_table_unit #(
	parameter int CPU_SLOTS   = rsvt_pkg::CPU_SLOTS_DEF,
	parameter int MAX_ENTRIES = rsvt_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] job_tag,
	input  logic [5:0]  cpu_request,
	input  logic [31:0] memory_request,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] granted_mask,
	output logic [31:0] granted_memory,
	output logic        fits,
	output logic [31:0] job_cpu_mask,
	output logic [5:0]  free_cpus,
	output logic [31:0] free_memory
);

	localparam int SCAN_N = (CPU_SLOTS < 32) ? CPU_SLOTS : 32;
	localparam logic [31:0] USABLE = (SCAN_N == 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << SCAN_N) - 64'd1);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RECOUNT,
		S_SCAN,
		S_ROT,
		S_DONE
	} state_t;

	state_t state_q;

	// node registers and free pool
	logic [31:0] present_q;
	logic [31:0] node_mem_q;
	logic [31:0] free_mask_q;
	logic [5:0]  free_cnt_q;
	logic [31:0] free_mem_q;
	logic [CNT_W-1:0] ecount_q;
	logic [CNT_W-1:0] rem_q;

	// current transaction
	logic [1:0]  cmd_q;
	logic [15:0] tag_q;
	logic [5:0]  creq_q;
	logic [31:0] mreq_q;

	// walkers and results
	logic [31:0] shm_q;
	logic [31:0] cursor_q;
	logic [5:0]  step_q;
	logic [5:0]  got_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [31:0] gmask_q;
	logic [31:0] gmem_q;
	logic [5:0]  gcnt_q;
	logic        fits_q;
	logic [31:0] jmask_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  o_status_q;
	logic [31:0] o_gmask_q;
	logic [31:0] o_gmem_q;
	logic        o_fits_q;
	logic [31:0] o_jmask_q;
	logic [5:0]  o_free_cnt_q;
	logic [31:0] o_free_mem_q;

	// cell chain
	rsvt_pkg::entry_t cell_d [MAX_ENTRIES];
	rsvt_pkg::entry_t head;
	rsvt_pkg::entry_t wr_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             shift_en;
	logic             head_match;
	logic             drop;
	logic [31:0]      gmem_n;
	logic [32:0]      mem_sum;
	logic [31:0]      new_present;
	logic [31:0]      new_node_mem;
	logic [31:0]      new_usable;
	logic             cfg_hit;
	logic             out_load;

	assign head       = cell_d[0];
	assign head_match = (head.tag == tag_q);
	assign drop       = (state_q == S_ROT) && (rem_q != '0) && head_match && !found_q
		&& (cmd_q == rsvt_pkg::CMD_RELEASE);
	assign gmem_n     = (mreq_q <= free_mem_q) ? mreq_q : free_mem_q;
	assign mem_sum    = {1'b0, free_mem_q} + {1'b0, gmem_q};

	// chain control: reserve appends at the tail, rotation pops the head and
	// re-appends it behind the last live entry unless it is the one released
	always_comb begin
		shift_en = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = ecount_q[IDX_W-1:0];
		wr_data  = head;
		if (state_q == S_SCAN && (step_q == 6'(SCAN_N) || got_q == creq_q)) begin
			wr_en   = 1'b1;
			wr_data = '{tag: tag_q, mask: gmask_q, mem: gmem_n, cnt: got_q};
		end else if (state_q == S_ROT && rem_q != '0) begin
			shift_en = 1'b1;
			wr_en    = !drop;
			wr_idx   = IDX_W'(ecount_q - CNT_W'(1));
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		rsvt_cell u_cell (
			.clk       (clk),
			.shift_en  (shift_en),
			.load_en   (wr_en && (wr_idx == IDX_W'(i))),
			.load_data (wr_data),
			.nbr_data  ((i == MAX_ENTRIES - 1) ? cell_d[i] : cell_d[(i + 1) % MAX_ENTRIES]),
			.data      (cell_d[i])
		);
	end

	// config decode
	assign cfg_hit      = cfg_we && (cfg_index == rsvt_pkg::REG_CPU_PRESENT
		|| cfg_index == rsvt_pkg::REG_NODE_MEMORY);
	assign new_present  = (cfg_index == rsvt_pkg::REG_CPU_PRESENT) ? cfg_wdata : present_q;
	assign new_node_mem = (cfg_index == rsvt_pkg::REG_NODE_MEMORY) ? cfg_wdata : node_mem_q;
	assign new_usable   = new_present & USABLE;

	// the done state moves its result into the output register
	assign out_load = !cfg_hit && (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			present_q   <= 32'hFFFF_FFFF;
			node_mem_q  <= '0;
			free_mask_q <= USABLE;
			free_cnt_q  <= 6'(SCAN_N);
			free_mem_q  <= '0;
			ecount_q    <= '0;
			rem_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				// reload the node and recount its cpus
				present_q   <= new_present;
				node_mem_q  <= new_node_mem;
				free_mask_q <= new_usable;
				shm_q       <= new_usable;
				free_cnt_q  <= '0;
				free_mem_q  <= new_node_mem;
				ecount_q    <= '0;
				step_q      <= '0;
				state_q     <= S_RECOUNT;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							cmd_q    <= cmd;
							tag_q    <= job_tag;
							creq_q   <= cpu_request;
							mreq_q   <= memory_request;
							status_q <= (rsvt_pkg::cmd_t'(cmd) == rsvt_pkg::CMD_RESERVE
								&& ecount_q == CNT_W'(MAX_ENTRIES))
								? rsvt_pkg::ST_FULL : rsvt_pkg::ST_OK;
							gmask_q  <= '0;
							gmem_q   <= '0;
							gcnt_q   <= '0;
							fits_q   <= (rsvt_pkg::cmd_t'(cmd) == rsvt_pkg::CMD_FITS)
								&& (cpu_request <= free_cnt_q)
								&& (memory_request <= free_mem_q);
							jmask_q  <= '0;
							found_q  <= 1'b0;
							unique case (rsvt_pkg::cmd_t'(cmd))
								rsvt_pkg::CMD_RESERVE: begin
									if (ecount_q == CNT_W'(MAX_ENTRIES)) begin
										// table full, nothing changes
										state_q  <= S_DONE;
									end else begin
										shm_q    <= free_mask_q;
										cursor_q <= 32'd1;
										step_q   <= '0;
										got_q    <= '0;
										state_q  <= S_SCAN;
									end
								end
								rsvt_pkg::CMD_FITS: begin
									state_q <= S_DONE;
								end
								rsvt_pkg::CMD_RELEASE, rsvt_pkg::CMD_QUERY: begin
									rem_q   <= ecount_q;
									state_q <= S_ROT;
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
					S_RECOUNT: begin
						if (step_q == 6'(SCAN_N)) begin
							state_q <= S_IDLE;
						end else begin
							free_cnt_q <= free_cnt_q + {5'd0, shm_q[0]};
							shm_q      <= shm_q >> 1;
							step_q     <= step_q + 6'd1;
						end
					end
					S_SCAN: begin
						if (step_q == 6'(SCAN_N) || got_q == creq_q) begin
							// grant found cpus and memory, entry is written by the chain
							free_mask_q <= free_mask_q & ~gmask_q;
							free_cnt_q  <= free_cnt_q - got_q;
							gmem_q      <= gmem_n;
							free_mem_q  <= free_mem_q - gmem_n;
							ecount_q    <= ecount_q + CNT_W'(1);
							state_q     <= S_DONE;
						end else begin
							if (shm_q[0]) begin
								gmask_q <= gmask_q | cursor_q;
								got_q   <= got_q + 6'd1;
							end
							shm_q    <= shm_q >> 1;
							cursor_q <= cursor_q << 1;
							step_q   <= step_q + 6'd1;
						end
					end
					S_ROT: begin
						if (rem_q == '0) begin
							if (cmd_q == rsvt_pkg::CMD_RELEASE) begin
								if (found_q) begin
									free_mask_q <= free_mask_q | gmask_q;
									free_cnt_q  <= free_cnt_q + gcnt_q;
									free_mem_q  <= mem_sum[32] ? 32'hFFFF_FFFF : mem_sum[31:0];
								end else begin
									status_q <= rsvt_pkg::ST_NOT_FOUND;
								end
							end
							state_q <= S_DONE;
						end else begin
							rem_q <= rem_q - CNT_W'(1);
							if (cmd_q == rsvt_pkg::CMD_QUERY && head_match) begin
								jmask_q <= jmask_q | head.mask;
							end
							if (drop) begin
								found_q  <= 1'b1;
								gmask_q  <= head.mask;
								gmem_q   <= head.mem;
								gcnt_q   <= head.cnt;
								ecount_q <= ecount_q - CNT_W'(1);
							end
						end
					end
					S_DONE: begin
						if (out_load) begin
							out_valid_q  <= 1'b1;
							o_status_q   <= status_q;
							o_gmask_q    <= gmask_q;
							o_gmem_q     <= gmem_q;
							o_fits_q     <= fits_q;
							o_jmask_q    <= jmask_q;
							o_free_cnt_q <= free_cnt_q;
							o_free_mem_q <= free_mem_q;
							state_q      <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = o_status_q;
	assign granted_mask   = o_gmask_q;
	assign granted_memory = o_gmem_q;
	assign fits           = o_fits_q;
	assign job_cpu_mask   = o_jmask_q;
	assign free_cpus      = o_free_cnt_q;
	assign free_memory    = o_free_mem_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecount_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= 6'(SCAN_N))
		else $error("free cpu count beyond usable cpus");

	a_scan_got: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (got_q <= creq_q))
		else $error("reserve granted more cpus than requested");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_status_q != rsvt_pkg::ST_OK) |-> (o_gmask_q == '0 && o_gmem_q == '0))
		else $error("failed transaction reports a grant");
`endif

endmodule
